[design/dord_pkg.sv]
// Shared types, register codes and helpers for the detection output row decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package dord_pkg;

  localparam int unsigned MaxClassesDef = 128;   // class columns scanned by the argmax
  localparam int unsigned ColW          = 13;    // saturating column counter
  localparam int unsigned ClsW          = 12;    // running argmax index
  localparam int unsigned QDepth        = 2;     // row queue depth, power of two
  localparam int unsigned QPtrW         = (QDepth > 1) ? $clog2(QDepth) : 1;

  // decode modes
  localparam logic [1:0] ModeYoloObj = 2'd0;
  localparam logic [1:0] ModeYolo    = 2'd1;
  localparam logic [1:0] ModeDet     = 2'd2;
  localparam logic [1:0] ModeDetM1   = 2'd3;

  // register indexes
  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegThr    = 2'd1;
  localparam logic [1:0] RegScaleX = 2'd2;
  localparam logic [1:0] RegScaleY = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] thr;
    logic [31:0] scale_x;
    logic [31:0] scale_y;
  } cfg_t;

  // one finished row as seen at its last beat
  typedef struct packed {
    logic [1:0]       mode;
    logic             len_ok;
    logic [3:0][31:0] box;     // yolo cx,cy,w,h or detection l,t,r,b
    logic [31:0]      cls;     // argmax index (yolo) or raw class value (detection)
    logic [31:0]      sa;      // best score (yolo) or row confidence (detection)
    logic [31:0]      sb;      // objectness
  } row_t;

  typedef struct packed {
    logic [7:0]  class_index;
    logic [16:0] confidence;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
  } res_t;

  function automatic logic [15:0] sat_s16(input logic signed [36:0] v);
    logic [15:0] r;
    if (v < -37'sd32768) begin
      r = 16'h8000;
    end else if (v > 37'sd32767) begin
      r = 16'h7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/detection_output_row_decoder.sv]
// Top level of the detection output row decoder: register file and channel wiring.
// Depends on dord_pkg, dord_front, dord_queue and dord_back.
//
//   Channel   Dir  Handshake              Beat payload
//   s_*       in   s_tvalid_i/s_tready_o  tdata[31:0] row_value, tlast row_last
//   m_*       out  m_tvalid_o/m_tready_i  tdata: class, confidence, box (see port)
//   APB       in   psel/penable/pready    4 registers at 0x0, 0x4, 0x8, 0xC
//
// Cycles: one row beat per cycle while the row queue is not full. A row
// result passes through the row queue, four pipeline stages and the result
// register; rows of any length, down to a single beat, stream back to back.
// Reset: asynchronous, active low; clears all row state, the queue and the
// pipeline, and loads the register defaults. No clearing pass is needed.
// Stalls: a held result freezes the back-end pipeline; the two-entry row queue
// absorbs finished rows, and s_tready_o drops only while the queue is full.
`default_nettype none

module detection_output_row_decoder import dord_pkg::*; #(
  parameter int unsigned MaxClasses = MaxClassesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // row_value [31:0]
  input  wire logic [31:0] s_tdata_i,
  input  wire logic        s_tlast_i,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // class_index [7:0], confidence [24:8], box_left [40:25], box_top [56:41],
  // box_width [72:57], box_height [88:73], zero fill [95:89]
  output logic [95:0]      m_tdata_o,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_q;
  logic wr_en;
  logic push, full, q_valid, pop;
  row_t push_row, q_row;
  res_t res;

  // register file: write on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= ModeYoloObj;
      cfg_q.thr     <= 17'd32768;
      cfg_q.scale_x <= 32'd65536;
      cfg_q.scale_y <= 32'd65536;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegMode:   cfg_q.mode    <= pwdata[1:0];
        RegThr:    cfg_q.thr     <= pwdata[16:0];
        RegScaleX: cfg_q.scale_x <= pwdata;
        RegScaleY: cfg_q.scale_y <= pwdata;
        default:   cfg_q.mode    <= cfg_q.mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMode:   prdata = {30'd0, cfg_q.mode};
      RegThr:    prdata = {15'd0, cfg_q.thr};
      RegScaleX: prdata = cfg_q.scale_x;
      RegScaleY: prdata = cfg_q.scale_y;
      default:   prdata = '0;
    endcase
  end

  // front end: column tracking and running argmax
  dord_front #(
    .MaxClasses(MaxClasses)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (cfg_q.mode),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .in_value_i (s_tdata_i),
    .in_last_i  (s_tlast_i),
    .push_o     (push),
    .row_o      (push_row),
    .full_i     (full)
  );

  // hold finished rows while the back end stalls
  dord_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .row_i   (push_row),
    .full_o  (full),
    .valid_o (q_valid),
    .row_o   (q_row),
    .pop_i   (pop)
  );

  // back end: score, threshold and box scaling
  dord_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_row_i     (q_row),
    .pop_o       (pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_o       (res)
  );

  // pack the result beat, first field lowest
  assign m_tdata_o = {7'd0, res.box_height, res.box_width, res.box_top, res.box_left,
                      res.confidence, res.class_index};

endmodule

`default_nettype wire

[design/dord_front.sv]
// Front end: accepts row beats, tracks the column, box fields and running argmax.
// Depends on dord_pkg; hands one row_t per finished row to the row queue.
`default_nettype none

module dord_front import dord_pkg::*; #(
  parameter int unsigned MaxClasses = MaxClassesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] in_value_i,
  input  wire logic        in_last_i,
  output logic             push_o,
  output row_t             row_o,
  input  wire logic        full_i
);

  localparam logic [ColW-1:0] ColMax = '1;

  logic [ColW-1:0]  col_q, col_d;
  logic [3:0][31:0] box_q, box_d;
  logic [31:0]      obj_q, obj_d;
  logic [31:0]      best_q, best_d;
  logic [ClsW-1:0]  bcls_q, bcls_d;
  logic [31:0]      rcv_q, rcv_d;
  logic [31:0]      rconf_q, rconf_d;
  logic             acc;
  logic             yolo;
  logic [ColW-1:0]  first;
  logic [ColW-1:0]  k;
  logic [ColW-1:0]  dpos;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign yolo       = (mode_i == ModeYoloObj) || (mode_i == ModeYolo);
  assign first      = (mode_i == ModeYoloObj) ? ColW'(5) : ColW'(4);
  assign k          = col_q - first;
  assign dpos       = col_q - ColW'(3);

  always_comb begin
    col_d   = col_q;
    box_d   = box_q;
    obj_d   = obj_q;
    best_d  = best_q;
    bcls_d  = bcls_q;
    rcv_d   = rcv_q;
    rconf_d = rconf_q;
    if (acc) begin
      if (col_q != ColMax) begin
        if (yolo) begin
          if (col_q < ColW'(4)) begin
            box_d[col_q[1:0]] = in_value_i;
          end else if ((mode_i == ModeYoloObj) && (col_q == ColW'(4))) begin
            obj_d = in_value_i;
          end else if ((col_q >= first) && (k < ColW'(MaxClasses))) begin
            // keep the first maximum
            if ((k == '0) || ($signed(in_value_i) > $signed(best_q))) begin
              best_d = in_value_i;
              bcls_d = k[ClsW-1:0];
            end
          end
        end else begin
          if (col_q == ColW'(1)) begin
            rcv_d = in_value_i;
          end else if (col_q == ColW'(2)) begin
            rconf_d = in_value_i;
          end else if ((col_q >= ColW'(3)) && (col_q <= ColW'(6))) begin
            box_d[dpos[1:0]] = in_value_i;
          end
        end
      end
      if (in_last_i) begin
        col_d = '0;
      end else if (col_q != ColMax) begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      box_q   <= '0;
      obj_q   <= '0;
      best_q  <= '0;
      bcls_q  <= '0;
      rcv_q   <= '0;
      rconf_q <= '0;
    end else begin
      col_q   <= col_d;
      box_q   <= box_d;
      obj_q   <= obj_d;
      best_q  <= best_d;
      bcls_q  <= bcls_d;
      rcv_q   <= rcv_d;
      rconf_q <= rconf_d;
    end
  end

  // snapshot the row including the update of its last beat
  always_comb begin
    row_o.mode = mode_i;
    row_o.box  = box_d;
    row_o.sb   = obj_d;
    unique case (mode_i)
      ModeYoloObj: row_o.len_ok = (col_q >= ColW'(5));
      ModeYolo:    row_o.len_ok = (col_q >= ColW'(4));
      default:     row_o.len_ok = (col_q >= ColW'(6));
    endcase
    if (yolo) begin
      row_o.cls = 32'(bcls_d);
      row_o.sa  = best_d;
    end else begin
      row_o.cls = rcv_d;
      row_o.sa  = rconf_d;
    end
  end

  assign push_o = acc && in_last_i;

endmodule

`default_nettype wire

[design/dord_queue.sv]
// Short row queue between the front end and the back end.
// Depends on dord_pkg for row_t and the depth constant.
`default_nettype none

module dord_queue import dord_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  row_t      row_i,
  output logic      full_o,
  output logic      valid_o,
  output row_t      row_o,
  input  wire logic pop_i
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  row_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign row_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/dord_back.sv]
// Back end: five-stage pipeline that scores, thresholds and scales one row.
// Depends on dord_pkg; pops row_t from the queue, drives the result register.
`default_nettype none

module dord_back import dord_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic q_valid_i,
  input  row_t      q_row_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_o
);

  logic adv;

  // stage 1: operands, magnitudes, objectness product, class
  logic                     s1_valid_q;
  logic                     s1_det_q, s1_len_ok_q, s1_gate_q, s1_mode0_q;
  logic [3:0][33:0]         s1_mag_q;
  logic [3:0]               s1_neg_q;
  logic [1:0]               s1_f33_q;
  logic signed [63:0]       s1_prod_q;
  logic [7:0]               s1_cls_q;
  logic [31:0]              s1_sa_q;

  // stage 2: partial products, decision, confidence
  logic                     s2_valid_q, s2_det_q, s2_emit_q;
  logic [3:0][49:0]         s2_pa_q, s2_pb_q;
  logic [3:0]               s2_neg_q;
  logic [1:0]               s2_f33_q;
  logic [7:0]               s2_cls_q;
  logic [16:0]              s2_conf_q;

  // stage 3: scaled magnitudes
  logic                     s3_valid_q, s3_det_q, s3_emit_q;
  logic [3:0][34:0]         s3_t_q;
  logic [3:0]               s3_neg_q;
  logic [7:0]               s3_cls_q;
  logic [16:0]              s3_conf_q;

  // stage 4: signed coordinates
  logic                     s4_valid_q, s4_det_q, s4_emit_q;
  logic [3:0][35:0]         s4_r_q;
  logic [7:0]               s4_cls_q;
  logic [16:0]              s4_conf_q;

  logic                     out_valid_q;
  res_t                     out_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  // ---------------- stage 1 ----------------
  logic                     c1_yolo, c1_mode0;
  logic [3:0][33:0]         c1_d;
  logic [3:0][33:0]         c1_mag;
  logic [3:0]               c1_neg;
  logic [31:0]              c1_cmag;
  logic signed [17:0]       c1_ci;
  logic [7:0]               c1_cls;

  always_comb begin
    c1_yolo  = (q_row_i.mode == ModeYoloObj) || (q_row_i.mode == ModeYolo);
    c1_mode0 = (q_row_i.mode == ModeYoloObj);
    for (int i = 0; i < 4; i++) begin
      c1_d[i] = 34'($signed(q_row_i.box[i]));
    end
    if (c1_yolo) begin
      // left/top edge doubled: 2*cx - w
      c1_d[0] = 34'($signed({q_row_i.box[0], 1'b0})) - 34'($signed(q_row_i.box[2]));
      c1_d[1] = 34'($signed({q_row_i.box[1], 1'b0})) - 34'($signed(q_row_i.box[3]));
    end
    for (int i = 0; i < 4; i++) begin
      c1_neg[i] = c1_d[i][33];
      c1_mag[i] = c1_d[i][33] ? (34'd0 - c1_d[i]) : c1_d[i];
    end
    // class: argmax index, or truncated class value
    c1_cmag = q_row_i.cls[31] ? (32'd0 - q_row_i.cls) : q_row_i.cls;
    c1_ci   = q_row_i.cls[31] ? -$signed({2'b00, c1_cmag[31:16]})
                              : $signed({2'b00, c1_cmag[31:16]});
    if (q_row_i.mode == ModeDetM1) begin
      c1_ci = c1_ci - 18'sd1;
    end
    if (c1_yolo) begin
      c1_cls = (q_row_i.cls > 32'd127) ? 8'd127 : q_row_i.cls[7:0];
    end else if (c1_ci < -18'sd1) begin
      c1_cls = 8'hff;
    end else if (c1_ci > 18'sd127) begin
      c1_cls = 8'd127;
    end else begin
      c1_cls = c1_ci[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_det_q    <= !c1_yolo;
      s1_mode0_q  <= c1_mode0;
      s1_len_ok_q <= q_row_i.len_ok;
      s1_gate_q   <= !c1_mode0 || ($signed(q_row_i.sb) > $signed({15'd0, cfg_i.thr}));
      s1_mag_q    <= c1_mag;
      s1_neg_q    <= c1_neg;
      s1_f33_q    <= {2{c1_yolo}};
      s1_prod_q   <= 64'($signed(q_row_i.sa)) * 64'($signed(q_row_i.sb));
      s1_cls_q    <= c1_cls;
      s1_sa_q     <= q_row_i.sa;
    end
  end

  // ---------------- stage 2 ----------------
  logic signed [47:0] c2_score;
  logic [3:0][15:0]   c2_sh;
  logic [3:0][15:0]   c2_sl;

  always_comb begin
    c2_score = s1_mode0_q ? s1_prod_q[63:16] : 48'($signed(s1_sa_q));
    for (int i = 0; i < 4; i++) begin
      c2_sh[i] = (i % 2 == 0) ? cfg_i.scale_x[31:16] : cfg_i.scale_y[31:16];
      c2_sl[i] = (i % 2 == 0) ? cfg_i.scale_x[15:0]  : cfg_i.scale_y[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_det_q  <= s1_det_q;
      s2_emit_q <= s1_len_ok_q && s1_gate_q &&
                   (c2_score > $signed({31'd0, cfg_i.thr}));
      if (c2_score < 48'sd0) begin
        s2_conf_q <= '0;
      end else if (c2_score > 48'sd65536) begin
        s2_conf_q <= 17'd65536;
      end else begin
        s2_conf_q <= c2_score[16:0];
      end
      s2_neg_q <= s1_neg_q;
      s2_f33_q <= s1_f33_q;
      s2_cls_q <= s1_cls_q;
      for (int i = 0; i < 4; i++) begin
        s2_pa_q[i] <= {16'd0, s1_mag_q[i]} * {34'd0, c2_sh[i]};
        s2_pb_q[i] <= {16'd0, s1_mag_q[i]} * {34'd0, c2_sl[i]};
      end
    end
  end

  // ---------------- stage 3 ----------------
  logic [3:0][50:0] c3_sum;
  logic [3:0][50:0] c3_shr;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      c3_sum[i] = {1'b0, s2_pa_q[i]} + {17'd0, s2_pb_q[i][49:16]};
      if ((i < 2) && s2_f33_q[i % 2]) begin
        c3_shr[i] = c3_sum[i] >> 17;
      end else begin
        c3_shr[i] = c3_sum[i] >> 16;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_det_q  <= s2_det_q;
      s3_emit_q <= s2_emit_q;
      s3_neg_q  <= s2_neg_q;
      s3_cls_q  <= s2_cls_q;
      s3_conf_q <= s2_conf_q;
      for (int i = 0; i < 4; i++) begin
        s3_t_q[i] <= c3_shr[i][34:0];
      end
    end
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_det_q  <= s3_det_q;
      s4_emit_q <= s3_emit_q;
      s4_cls_q  <= s3_cls_q;
      s4_conf_q <= s3_conf_q;
      for (int i = 0; i < 4; i++) begin
        s4_r_q[i] <= s3_neg_q[i] ? (36'd0 - {1'b0, s3_t_q[i]}) : {1'b0, s3_t_q[i]};
      end
    end
  end

  // ---------------- result register ----------------
  logic signed [36:0] c5_w, c5_h;

  always_comb begin
    if (s4_det_q) begin
      c5_w = 37'($signed(s4_r_q[2])) - 37'($signed(s4_r_q[0])) + 37'sd1;
      c5_h = 37'($signed(s4_r_q[3])) - 37'($signed(s4_r_q[1])) + 37'sd1;
    end else begin
      c5_w = 37'($signed(s4_r_q[2]));
      c5_h = 37'($signed(s4_r_q[3]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_valid_q && s4_emit_q) begin
      out_q.class_index <= s4_cls_q;
      out_q.confidence  <= s4_conf_q;
      out_q.box_left    <= sat_s16(37'($signed(s4_r_q[0])));
      out_q.box_top     <= sat_s16(37'($signed(s4_r_q[1])));
      out_q.box_width   <= sat_s16(c5_w);
      out_q.box_height  <= sat_s16(c5_h);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q && s4_emit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

[design/dord_checker.sv]
// Port-level checks for the detection output row decoder, bound to the top level.
// Depends on dord_pkg for register indexes and on the top level's ports.
`default_nettype none

module dord_checker import dord_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [31:0] s_tdata_i,
  input wire logic        s_tlast_i,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic [95:0] m_tdata_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result beat dropped or changed while stalled");

  // confidence never above one
  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[24:8] <= 17'd65536))
    else $error("confidence out of range");

  // class never below minus one
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[7] |-> (m_tdata_o[7:0] == 8'hff))
    else $error("class index below minus one");

  // a written mode register reads back what was written on the next cycle
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[3:2] == RegMode) |=>
    (paddr[3:2] != RegMode) || (prdata[1:0] == $past(pwdata[1:0])) || (psel && pwrite))
    else $error("mode register readback mismatch");

  // no result from an idle block with an empty input side after reset
  a_no_spurious: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_o || !$past(rst_ni, 1) == 1'b0)
    else $error("result beat right after reset");

endmodule

bind detection_output_row_decoder dord_checker u_dord_checker (.*);

`default_nettype wire

[bench/tb_detection_output_row_decoder.sv]
// Self-checking bench for detection_output_row_decoder: streams proposal rows,
// reprograms the APB registers between phases and checks every candidate beat.
// Depends on dord_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_detection_output_row_decoder import dord_pkg::*; ();

  localparam int unsigned SETTLE  = 10;       // wait for the back-end pipeline to empty, with margin
  localparam int unsigned TIMEOUT = 400000;   // generous cap on the whole run
  localparam int unsigned COL_CAP = 8191;     // column counter saturation point

  // Mirror of the decoder: tracks the row state and the register file, turns
  // every accepted row beat into the candidate it should produce, and checks
  // candidate beats against the oldest one still owed.
  class candidate_board;
    res_t        owed_q[$];
    int unsigned errors = 0;

    logic [1:0]  mode  = ModeYoloObj;
    logic [16:0] thr   = 17'd32768;
    logic [31:0] scl_x = 32'd65536;
    logic [31:0] scl_y = 32'd65536;

    int unsigned col = 0;
    longint      box[4] = '{0, 0, 0, 0};
    longint      obj = 0;
    longint      best = 0;
    int unsigned best_k = 0;
    longint      cls_raw = 0;
    longint      conf_raw = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegMode:   mode  = val[1:0];
        RegThr:    thr   = val[16:0];
        RegScaleX: scl_x = val;
        RegScaleY: scl_y = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // trunc(d * s / 2^frac) toward zero, s unsigned Q16.16
    function longint scale_down(longint d, logic [31:0] s, int unsigned frac);
      longint unsigned m;
      longint unsigned t;
      m = (d < 0) ? -d : d;
      t = m * s[31:16] + ((m * s[15:0]) >> 16);
      t = t >> (frac - 16);
      return (d < 0) ? -longint'(t) : longint'(t);
    endfunction

    function void take_beat(logic [31:0] value, logic last);
      longint      v;
      int unsigned c;
      int unsigned first;
      logic [1:0]  md;
      longint      th;
      longint      score;
      longint      cls;
      longint      conf;
      longint      l, t, w, h, r, b;
      longint      q;
      longint unsigned mag;
      logic        emit;
      logic        gate;
      res_t        want;
      v = longint'($signed(value));
      c = col;
      md = mode;
      th = longint'(thr);
      first = (md == ModeYoloObj) ? 5 : 4;
      emit = 1'b0;
      cls = 0; conf = 0; l = 0; t = 0; w = 0; h = 0;

      // store the element under the mode in force now
      if (c < COL_CAP) begin
        if (md == ModeYoloObj || md == ModeYolo) begin
          if (c < 4) begin
            box[c] = v;
          end else if (md == ModeYoloObj && c == 4) begin
            obj = v;
          end else if (c >= first && c - first < MaxClassesDef) begin
            // first maximum wins on ties
            if (c == first || v > best) begin
              best = v;
              best_k = c - first;
            end
          end
        end else begin
          if (c == 1) cls_raw = v;
          else if (c == 2) conf_raw = v;
          else if (c >= 3 && c <= 6) box[c - 3] = v;
        end
      end

      if (last) begin
        if (md == ModeYoloObj || md == ModeYolo) begin
          if (c >= first) begin
            gate = 1'b1;
            score = best;
            if (md == ModeYoloObj) begin
              gate = obj > th;
              score = (best * obj) >>> 16;
            end
            if (gate && score > th) begin
              emit = 1'b1;
              cls = longint'(best_k);
              conf = score;
              l = scale_down(2 * box[0] - box[2], scl_x, 33);
              t = scale_down(2 * box[1] - box[3], scl_y, 33);
              w = scale_down(box[2], scl_x, 32);
              h = scale_down(box[3], scl_y, 32);
            end
          end
        end else if (c >= 6 && conf_raw > th) begin
          emit = 1'b1;
          mag = (cls_raw < 0) ? -cls_raw : cls_raw;
          cls = longint'(mag >> 16);
          if (cls_raw < 0) cls = -cls;
          if (md == ModeDetM1) cls = cls - 1;
          conf = conf_raw;
          l = scale_down(box[0], scl_x, 32);
          t = scale_down(box[1], scl_y, 32);
          r = scale_down(box[2], scl_x, 32);
          b = scale_down(box[3], scl_y, 32);
          w = r - l + 1;
          h = b - t + 1;
        end
        if (emit) begin
          q = clamp(cls, -1, 127);         want.class_index = q[7:0];
          q = clamp(conf, 0, 65536);       want.confidence  = q[16:0];
          q = clamp(l, -32768, 32767);     want.box_left    = q[15:0];
          q = clamp(t, -32768, 32767);     want.box_top     = q[15:0];
          q = clamp(w, -32768, 32767);     want.box_width   = q[15:0];
          q = clamp(h, -32768, 32767);     want.box_height  = q[15:0];
          owed_q.insert(owed_q.size(), want);
        end
        col = 0;
      end else if (c < COL_CAP) begin
        col = c + 1;
      end
    endfunction

    task check_field(string name, logic [16:0] got, logic [16:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task match_result(logic [95:0] d);
      res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("candidate %h with none owed", d));
      end else begin
        want = owed_q.pop_front();
        check_field("class_index", d[7:0],   want.class_index);
        check_field("confidence",  d[24:8],  want.confidence);
        check_field("box_left",    d[40:25], want.box_left);
        check_field("box_top",     d[56:41], want.box_top);
        check_field("box_width",   d[72:57], want.box_width);
        check_field("box_height",  d[88:73], want.box_height);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // row_value [31:0]
  logic [31:0] s_tdata_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  // class_index [7:0], confidence [24:8], box_left [40:25], box_top [56:41],
  // box_width [72:57], box_height [88:73], zero fill [95:89]
  logic [95:0] m_tdata_o;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  candidate_board board = new();

  logic        calm = 1'b0;         // high: neither side idles
  logic [31:0] last_score = '0;     // reused to force argmax ties
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  detection_output_row_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Catch a hung run: report failure once the cycle budget is spent.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT) begin
      $display("tb_detection_output_row_decoder: errors");
      $finish;
    end
  end

  // Result side back-pressure: short random drops of tready, now and then a
  // longer hold so the row queue fills and s_tready_o has to drop too.
  always @(posedge clk_i) begin
    if (calm) begin
      m_tready_i <= 1'b1;
    end else if (hold_left != 0) begin
      m_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(99) < 2) begin
      m_tready_i <= 1'b0;
      hold_left <= $urandom_range(3, 20);
    end else begin
      m_tready_i <= ($urandom_range(99) >= 8);
    end
  end

  // Watch both handshakes with the values present before the edge: predict on
  // every accepted row beat, check on every accepted candidate beat.
  always @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) board.take_beat(s_tdata_i, s_tlast_i);
    if (m_tvalid_o && m_tready_i) board.match_result(m_tdata_o);
  end

  // Offer one row beat, idling at random first; return at the accepting edge.
  // Valid stays high into the next beat unless that beat idles.
  task automatic send_beat(logic [31:0] data, logic last);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= data;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // Stop sending, wait for every owed candidate, then let the pipeline settle
  // so rows that produce nothing are out of the block too.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then one quiet cycle so back-to-back
  // writes never touch psel twice in one step.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [1:0] md, logic [16:0] th, logic [31:0] sx,
                             logic [31:0] sy);
    reg_write(RegMode, {30'd0, md});
    reg_write(RegThr, {15'd0, th});
    reg_write(RegScaleX, sx);
    reg_write(RegScaleY, sy);
  endtask

  function automatic logic [16:0] pick_thr();
    case ($urandom_range(6))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd65537;
      3: return 17'h1FFFF;
      4: return 17'd32768;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(32'h0000_8000, 32'h0004_0000);
    endcase
  endfunction

  // Row length: mostly well formed, some short, a few long (extra detection
  // columns, or more classes than the argmax scans).
  function automatic int unsigned pick_len(logic [1:0] md);
    int unsigned need;
    int unsigned r;
    need = (md == ModeYoloObj) ? 6 : ((md == ModeYolo) ? 5 : 7);
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(1, need - 1);
    if (r == 8 && md <= ModeYolo) return $urandom_range(128, 140);
    if (r < 14) return (md <= ModeYolo) ? need + $urandom_range(8, 20) : $urandom_range(8, 12);
    return (md <= ModeYolo) ? need + $urandom_range(0, 7) : 7;
  endfunction

  // Element content by column role, with raw noise and the field extremes mixed in.
  function automatic logic [31:0] pick_value(logic [1:0] md, int unsigned c);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return $urandom();
    if (r < 10) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    if (md <= ModeYolo) begin
      if (c < 2) return $urandom_range(0, 1344 << 16) - (64 << 16);
      if (c < 4) return $urandom_range(0, 300 << 16);
      if (md == ModeYoloObj && c == 4) return $urandom_range(0, 70000);
      if (r < 20) return last_score;
      last_score = $urandom_range(0, 65536);
      return last_score;
    end
    case (c)
      0: return $urandom_range(0, 3);
      1: begin
        if (r < 16) return -(($urandom_range(0, 3) << 16) | $urandom_range(0, 65535));
        return ($urandom_range(0, 130) << 16) | $urandom_range(0, 65535);
      end
      2: return $urandom_range(0, 70000);
      3, 4, 5, 6: return $urandom_range(0, 1400 << 16) - (100 << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_row(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(pick_value(board.mode, i), i == len - 1);
    end
  endtask

  initial begin
    int unsigned beats;
    int unsigned len;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset register values first.
    // YOLO row with objectness; the two class scores tie, so class 0 wins.
    send_beat(32'h000A_8000, 1'b0);    // cx 10.5
    send_beat(32'h0014_0000, 1'b0);    // cy 20.0
    send_beat(32'h0004_0000, 1'b0);    // w 4.0
    send_beat(32'h0006_4000, 1'b0);    // h 6.25
    send_beat(32'd58982, 1'b0);        // objectness 0.9
    send_beat(32'd49152, 1'b0);        // class 0: 0.75
    send_beat(32'd49152, 1'b1);        // class 1: same score
    // Single-beat row is too short to give anything.
    send_beat(32'h8000_0000, 1'b1);

    // YOLO without objectness at the extremes: zero threshold, full and zero
    // scales, so the x box fields saturate and the y box fields come to zero.
    drain();
    load_config(ModeYolo, 17'd0, 32'hFFFF_FFFF, 32'd0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0001, 1'b1);

    // Detection row past seven columns, threshold above range: the huge
    // confidence still passes and saturates.
    drain();
    load_config(ModeDet, 17'h1FFFF, 32'h0002_0000, 32'h0002_0000);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0003_B333, 1'b0);    // class 3.7
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h000A_0000, 1'b0);
    send_beat(32'h0014_0000, 1'b0);
    send_beat(32'h001E_8000, 1'b0);
    send_beat(32'h0028_4000, 1'b0);
    send_beat(32'h1234_5678, 1'b1);    // ignored column

    // Mode change within a row: start as class-minus-one detection, finish
    // as YOLO without objectness; the row end follows the new mode.
    drain();
    load_config(ModeDetM1, 17'd100, 32'h0001_8000, 32'h0000_C000);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFD_8000, 1'b0);    // class -2.5
    send_beat(32'h0000_8000, 1'b0);
    send_beat(32'h0005_0000, 1'b0);
    drain();
    reg_write(RegMode, {30'd0, ModeYolo});
    send_beat(32'h0000_3333, 1'b0);
    send_beat(32'h0000_9999, 1'b0);
    send_beat(32'h0000_9999, 1'b1);

    // Random phases: one register setting per phase, modes in turn. Phases two
    // and three run with no idling on either side.
    for (int unsigned ph = 0; ph < 12; ph++) begin
      drain();
      calm <= (ph == 2 || ph == 3);
      load_config(2'(ph % 4), pick_thr(), pick_scale(), pick_scale());
      beats = 0;
      while (beats < 150) begin
        len = pick_len(board.mode);
        send_row(len);
        beats += len;
        // hold off now and then until the block has caught up
        if ($urandom_range(99) < 3) drain();
      end
    end

    drain();
    if (board.pending() != 0) board.report($sformatf("%0d candidates never came", board.pending()));
    if (board.errors == 0) begin
      $display("tb_detection_output_row_decoder: clean");
    end else begin
      $display("tb_detection_output_row_decoder: errors");
    end
    $finish;
  end

endmodule

[detection_output_row_decoder.f]
design/dord_pkg.sv
design/dord_front.sv
design/dord_queue.sv
design/dord_back.sv
design/detection_output_row_decoder.sv
design/dord_checker.sv
bench/tb_detection_output_row_decoder.sv
